### hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants shared by the source text tokenizer modules
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int LINE_W = 20;
    localparam int COL_W  = 16;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NUMBER = 3'd1;
    localparam logic [2:0] MODE_IDENT  = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_UNDEF  = 3'd4;

    localparam logic [4:0] KIND_NUMBER = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_I8     = 5'd2;
    localparam logic [4:0] KIND_I16    = 5'd3;
    localparam logic [4:0] KIND_I32    = 5'd4;
    localparam logic [4:0] KIND_I64    = 5'd5;
    localparam logic [4:0] KIND_U8     = 5'd6;
    localparam logic [4:0] KIND_U16    = 5'd7;
    localparam logic [4:0] KIND_U32    = 5'd8;
    localparam logic [4:0] KIND_U64    = 5'd9;
    localparam logic [4:0] KIND_F32    = 5'd10;
    localparam logic [4:0] KIND_F64    = 5'd11;
    localparam logic [4:0] KIND_STRING = 5'd12;
    localparam logic [4:0] KIND_PLUS   = 5'd13;
    localparam logic [4:0] KIND_MINUS  = 5'd14;
    localparam logic [4:0] KIND_STAR   = 5'd15;
    localparam logic [4:0] KIND_SLASH  = 5'd16;
    localparam logic [4:0] KIND_EQUAL  = 5'd17;
    localparam logic [4:0] KIND_SEMI   = 5'd18;
    localparam logic [4:0] KIND_UNDEF  = 5'd19;
    localparam logic [4:0] KIND_END    = 5'd20;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } stt_in_t;

    typedef struct packed {
        logic [4:0]        token_kind;
        logic [LINE_W-1:0] token_line;
        logic [COL_W-1:0]  token_column;
        logic [4:0]        value_length;
        logic [7:0]        value_byte;
        logic [4:0]        byte_index;
        logic              last_of_token;
    } stt_out_t;

    // token header passed from the scanner to the replay side
    typedef struct packed {
        logic [4:0]        kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [6:0]        count;
        logic              bank;
    } stt_tok_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

    function automatic logic [4:0] sym_kind(input logic [7:0] b);
        case (b)
            8'h2b:   return KIND_PLUS;
            8'h2d:   return KIND_MINUS;
            8'h2a:   return KIND_STAR;
            8'h2f:   return KIND_SLASH;
            8'h3d:   return KIND_EQUAL;
            8'h3b:   return KIND_SEMI;
            default: return KIND_UNDEF;
        endcase
    endfunction

    // keyword match on the first three stored bytes, first byte on top
    function automatic logic [4:0] ident_kind(input logic [6:0] cnt,
                                              input logic [23:0] s);
        logic [4:0] k;
        k = KIND_IDENT;
        if (cnt == 7'd2) begin
            case (s[23:8])
                16'h6938: k = KIND_I8;
                16'h7538: k = KIND_U8;
                default:  k = KIND_IDENT;
            endcase
        end else if (cnt == 7'd3) begin
            case (s)
                24'h693136: k = KIND_I16;
                24'h693332: k = KIND_I32;
                24'h693634: k = KIND_I64;
                24'h753136: k = KIND_U16;
                24'h753332: k = KIND_U32;
                24'h753634: k = KIND_U64;
                24'h663332: k = KIND_F32;
                24'h663634: k = KIND_F64;
                default:    k = KIND_IDENT;
            endcase
        end
        return k;
    endfunction

endpackage

### hdl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// front end: classifies bytes, tracks position, writes value bytes to a bank
// ----------------------------------------------------------------------------
module stt_scan import stt_pkg::*; #(
    parameter int MAX_VALUE = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  stt_in_t         in_word,
    output logic            tok_valid,
    input  logic            tok_ready,
    output stt_tok_t        tok,
    output logic            wr_en,
    output logic            wr_bank,
    output logic [5:0]      wr_addr,
    output logic [7:0]      wr_data,
    input  logic [1:0]      bank_busy
);

    localparam logic [6:0] CAP = 7'(MAX_VALUE - 1);

    logic [2:0]        mode_reg, mode_next;
    logic              dot_reg, dot_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [LINE_W-1:0] line_reg, line_next, sline_reg, sline_next;
    logic [COL_W-1:0]  col_reg, col_next, scol_reg, scol_next;
    logic              bank_reg, bank_next;
    logic [23:0]       kw_reg, kw_next;
    // pending byte that must be rehandled from idle after a token closes
    logic              redo_reg, redo_next;
    logic [7:0]        rbyte_reg, rbyte_next;
    logic              eot_reg, eot_next;

    logic [7:0] b;
    logic       work;
    logic       stall;

    // the current bank must be free and the token queue must have room
    assign stall = bank_busy[bank_reg] | ~tok_ready;
    assign full  = redo_reg | stall;
    assign work  = (redo_reg | push) & ~stall;
    assign b     = redo_reg ? rbyte_reg : in_word.text_byte;

    always_comb
    begin
        logic [COL_W-1:0] cinc;
        logic [4:0] k;
        logic       close, idle_handle, ending;
        cinc = (col_reg < COL_MAX) ? col_reg + 1'b1 : col_reg;
        mode_next = mode_reg;
        dot_next = dot_reg;
        cnt_next = cnt_reg;
        line_next = line_reg;
        col_next = col_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        bank_next = bank_reg;
        kw_next = kw_reg;
        redo_next = redo_reg;
        rbyte_next = rbyte_reg;
        eot_next = eot_reg;
        tok_valid = 1'b0;
        tok = '0;
        wr_en = 1'b0;
        wr_bank = bank_reg;
        wr_addr = cnt_reg[5:0];
        wr_data = b;
        close = 1'b0;
        idle_handle = 1'b0;
        k = KIND_UNDEF;
        ending = redo_reg ? eot_reg : (in_word.end_of_text | (in_word.text_byte == 8'd0));
        case (mode_reg)
            MODE_NUMBER: k = KIND_NUMBER;
            MODE_IDENT:  k = ident_kind(cnt_reg, kw_reg);
            MODE_STRING: k = KIND_STRING;
            default:     k = KIND_UNDEF;
        endcase
        if (work) begin
            redo_next = 1'b0;
            eot_next = 1'b0;
            if (ending) begin
                if (mode_reg != MODE_IDLE) begin
                    close = 1'b1;
                    redo_next = 1'b1;
                    eot_next = 1'b1;
                end else begin
                    tok_valid = 1'b1;
                    tok = '{KIND_END, line_reg, col_reg, 7'd0, bank_reg};
                    bank_next = ~bank_reg;
                    line_next = 20'd1;
                    col_next = 16'd1;
                    sline_next = 20'd1;
                    scol_next = 16'd1;
                    cnt_next = 7'd0;
                    dot_next = 1'b0;
                end
            end else begin
                case (mode_reg)
                    MODE_NUMBER:
                        if (is_digit(b) || (b == 8'h2e && !dot_reg)) begin
                            if (b == 8'h2e) dot_next = 1'b1;
                            wr_en = cnt_reg < CAP;
                            col_next = cinc;
                        end else if (is_alpha(b)) begin
                            mode_next = MODE_UNDEF;
                            wr_en = cnt_reg < CAP;
                            col_next = cinc;
                        end else close = 1'b1;
                    MODE_IDENT:
                        if (is_alpha(b) || is_digit(b) || b == 8'h5f) begin
                            wr_en = cnt_reg < CAP;
                            col_next = cinc;
                        end else close = 1'b1;
                    MODE_STRING:
                    begin
                        col_next = cinc;
                        if (b == 8'h22) begin
                            tok_valid = 1'b1;
                            tok = '{KIND_STRING, sline_reg, scol_reg, cnt_reg, bank_reg};
                            bank_next = ~bank_reg;
                            mode_next = MODE_IDLE;
                            cnt_next = 7'd0;
                        end else wr_en = cnt_reg < CAP;
                    end
                    MODE_UNDEF:
                        if (!is_space(b)) begin
                            wr_en = cnt_reg < CAP;
                            col_next = cinc;
                        end else close = 1'b1;
                    default: idle_handle = 1'b1;
                endcase
                if (close) begin
                    redo_next = 1'b1;
                    eot_next = 1'b0;
                end
            end
            if (close) begin
                tok_valid = 1'b1;
                tok = '{k, sline_reg, scol_reg, cnt_reg, bank_reg};
                bank_next = ~bank_reg;
                mode_next = MODE_IDLE;
                cnt_next = 7'd0;
                rbyte_next = b;
            end
            if (idle_handle) begin
                if (b == 8'h0a) begin
                    if (line_reg < LINE_MAX) line_next = line_reg + 1'b1;
                    col_next = 16'd1;
                end else if (is_space(b)) col_next = cinc;
                else begin
                    sline_next = line_reg;
                    scol_next = col_reg;
                    dot_next = 1'b0;
                    col_next = cinc;
                    wr_addr = 6'd0;
                    if (is_digit(b)) begin
                        mode_next = MODE_NUMBER; wr_en = 1'b1; cnt_next = 7'd1;
                    end else if (is_alpha(b) || b == 8'h5f) begin
                        mode_next = MODE_IDENT; wr_en = 1'b1; cnt_next = 7'd1;
                    end else if (b == 8'h22) begin
                        mode_next = MODE_STRING; cnt_next = 7'd0;
                    end else if (sym_kind(b) != KIND_UNDEF) begin
                        wr_en = 1'b1;
                        tok_valid = 1'b1;
                        tok = '{sym_kind(b), line_reg, col_reg, 7'd1, bank_reg};
                        bank_next = ~bank_reg;
                        cnt_next = 7'd0;
                    end else begin
                        mode_next = MODE_UNDEF; wr_en = 1'b1; cnt_next = 7'd1;
                    end
                end
            end else if (wr_en) cnt_next = cnt_reg + 1'b1;
            if (wr_en && wr_addr < 6'd3 && !idle_handle)
                kw_next[23 - 8*wr_addr[1:0] -: 8] = b;
            if (wr_en && idle_handle) kw_next = {b, 16'h0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            dot_reg <= 1'b0;
            cnt_reg <= 7'd0;
            line_reg <= 20'd1;
            col_reg <= 16'd1;
            sline_reg <= 20'd1;
            scol_reg <= 16'd1;
            bank_reg <= 1'b0;
            redo_reg <= 1'b0;
            eot_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            dot_reg <= dot_next;
            cnt_reg <= cnt_next;
            line_reg <= line_next;
            col_reg <= col_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            bank_reg <= bank_next;
            redo_reg <= redo_next;
            eot_reg <= eot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kw_reg <= kw_next;
        rbyte_reg <= rbyte_next;
    end

`ifndef SYNTH
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CAP)
        else $error("value count beyond capacity");
    a_redo_idle: assert property (@(posedge clk) disable iff (!rst_n)
        redo_reg |-> mode_reg == MODE_IDLE)
        else $error("rehandle pending outside idle");
    a_tok_bank: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |=> bank_reg != $past(bank_reg))
        else $error("bank not swapped after token");
`endif

endmodule

### hdl/stt_emit.sv
// ----------------------------------------------------------------------------
// stt_emit
// back end: two value banks, token queue, replays each token as result words
// ----------------------------------------------------------------------------
module stt_emit import stt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  stt_tok_t   tok,
    input  logic       wr_en,
    input  logic       wr_bank,
    input  logic [5:0] wr_addr,
    input  logic [7:0] wr_data,
    output logic [1:0] bank_busy,
    output logic       empty,
    input  logic       pop,
    output stt_out_t   out_word
);

    logic [7:0] mem [0:127];
    stt_tok_t   q_reg [0:1];
    logic [1:0] qv_reg;
    logic       qh_reg;
    logic       tail;
    logic [5:0] idx_reg;
    logic       ov_reg;
    stt_tok_t   cur;
    logic [5:0] ridx;
    logic       adv, rd_go;
    logic [7:0] rd_reg;
    stt_out_t   o_reg;

    assign tok_ready = ~(qv_reg[0] & qv_reg[1]);
    assign cur = q_reg[qh_reg];
    // new token goes behind the head, or into the head slot when the queue is empty
    assign tail = qh_reg ^ qv_reg[qh_reg];
    // a bank stays busy until the read of its token's last value byte is issued
    assign bank_busy[0] = (qv_reg[0] && q_reg[0].bank == 1'b0) ||
                          (qv_reg[1] && q_reg[1].bank == 1'b0);
    assign bank_busy[1] = (qv_reg[0] && q_reg[0].bank == 1'b1) ||
                          (qv_reg[1] && q_reg[1].bank == 1'b1);
    assign empty = ~ov_reg;
    assign out_word = o_reg;
    assign rd_go = qv_reg[qh_reg] && (!ov_reg || pop);
    assign adv = rd_go && ({1'b0, idx_reg} + 7'd1 >= cur.count);
    assign ridx = idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[{wr_bank, wr_addr}] <= wr_data;
        rd_reg <= mem[{cur.bank, ridx}];
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid) q_reg[tail] <= tok;
    end

    // output word built in the cycle after the read address is issued
    logic       st_v_reg;
    stt_tok_t   st_tok_reg;
    logic [5:0] st_idx_reg;
    logic       st_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qv_reg <= 2'b00;
            qh_reg <= 1'b0;
            idx_reg <= 6'd0;
            ov_reg <= 1'b0;
            st_v_reg <= 1'b0;
        end else begin
            logic [1:0] v;
            v = qv_reg;
            st_v_reg <= 1'b0;
            if (ov_reg && pop) ov_reg <= 1'b0;
            if (st_v_reg) ov_reg <= 1'b1;
            if (rd_go && !st_v_reg) begin
                st_v_reg <= 1'b1;
                if (adv) begin
                    v[qh_reg] = 1'b0;
                    qh_reg <= ~qh_reg;
                    idx_reg <= 6'd0;
                end else idx_reg <= idx_reg + 1'b1;
            end
            if (tok_valid) v[tail] = 1'b1;
            qv_reg <= v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_go && !st_v_reg) begin
            st_tok_reg <= cur;
            st_idx_reg <= idx_reg;
            st_last_reg <= adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_v_reg) begin
            o_reg.token_kind <= st_tok_reg.kind;
            o_reg.token_line <= st_tok_reg.line;
            o_reg.token_column <= st_tok_reg.column;
            o_reg.value_length <= st_tok_reg.count[4:0];
            o_reg.value_byte <= (st_tok_reg.count == 7'd0) ? 8'd0 : rd_reg;
            o_reg.byte_index <= (st_tok_reg.count == 7'd0) ? 5'd0 : st_idx_reg[4:0];
            o_reg.last_of_token <= st_last_reg;
        end
    end

`ifndef SYNTH
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        st_v_reg |-> (!ov_reg || pop))
        else $error("result word overwritten");
    a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_ready)
        else $error("token pushed into full queue");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        qv_reg[qh_reg] && q_reg[qh_reg].count != 7'd0 |-> {1'b0, idx_reg} < q_reg[qh_reg].count)
        else $error("replay index beyond token");
`endif

endmodule

### hdl/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// cuts a byte stream into tokens and replays each as a run of result words
// ----------------------------------------------------------------------------
// One word in is one source byte. A token leaves as one result word per
// stored value byte (one word if the value is empty), each repeating kind,
// start line, start column and length. A scanner takes one byte a cycle
// while full is low and writes value bytes into one of two banks; a byte
// that closes a token is held and handled again from idle (full is high
// while it waits), and end of text behind an open token first closes that
// token and then gives the end token. The replay side does not issue a new
// value byte read while the word of the previous one is still staged; the
// scanner also stalls (full) while the bank it would write next is still
// waiting to be replayed, that is while both banks hold tokens. Results
// queue behind one output register, so a stalled pop does not lose words.
module source_text_tokenizer_core import stt_pkg::*; #(
    parameter int MAX_VALUE = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  stt_in_t  in_word,
    output logic     empty,
    input  logic     pop,
    output stt_out_t out_word
);

    // scanner to replay handoff
    logic       tok_valid, tok_ready;
    stt_tok_t   tok;
    logic       wr_en, wr_bank;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic [1:0] bank_busy;

    stt_scan #(.MAX_VALUE(MAX_VALUE)) u_scan (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
        .bank_busy(bank_busy)
    );

    stt_emit u_emit (
        .clk(clk), .rst_n(rst_n), .tok_valid(tok_valid), .tok_ready(tok_ready),
        .tok(tok), .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr),
        .wr_data(wr_data), .bank_busy(bank_busy), .empty(empty), .pop(pop),
        .out_word(out_word)
    );

`ifndef SYNTH
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_word.token_kind == KIND_END |-> out_word.last_of_token)
        else $error("end token not single word");
    a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_word.value_length == 5'd0 |-> out_word.value_byte == 8'd0)
        else $error("empty value carries a byte");
    a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");
`endif

endmodule
